// ----- rtl/huffman_code_builder_macros.svh -----
// assertion macros for the huffman code builder checker
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// same-cycle implication
`define HCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("huffman code builder check failed");

// next-cycle implication
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("huffman code builder check failed");

`endif

// ----- rtl/hcb_pkg.sv -----
// shared widths and defaults for the huffman code builder
`timescale 1ns / 1ps
package hcb_pkg;
  localparam int SYM_W = 8;
  localparam int FREQ_W = 16;
  localparam int CODE_W = 63;
  localparam int LEN_W = 6;
  localparam int MAX_SYMBOLS_DEF = 64;
endpackage

// ----- rtl/huffman_code_builder.sv -----
// huffman code builder: loads symbol pairs, builds the tree, emits codes in preorder
//
//   channel | signals                                   | role
//   in      | in_valid in_ready symbol frequency last   | one (symbol, frequency) pair
//   out     | out_valid out_ready symbol_res code_bits  | one code per loaded symbol
//           | code_length final_res                     |
//
// loading accepts items back to back while in_ready is high; the last item starts the build
// each merge is two scans of the shared compare unit over the weight memory,
//   so n symbols build in (n - 1) merges
// preorder walk: S_VISIT, then S_KIDS or S_LEAF; S_POP after all but the last leaf
// in_ready is low from the last item until the final code enters the output register
// an output stall holds the walk; reset clears control state, memories need none
`timescale 1ns / 1ps
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hcb_pkg::SYM_W-1:0]  symbol,
  input  logic [hcb_pkg::FREQ_W-1:0] frequency,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hcb_pkg::SYM_W-1:0]  symbol_res,
  output logic [hcb_pkg::CODE_W-1:0] code_bits,
  output logic [hcb_pkg::LEN_W-1:0]  code_length,
  output logic                       final_res
);
  localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
  localparam int IW = $clog2(2 * MAX_SYMBOLS);
  localparam int LW = $clog2(MAX_SYMBOLS);
  localparam int CW = LW + 1;
  localparam int WW = hcb_pkg::FREQ_W + LW;
  localparam int SW = IW + hcb_pkg::CODE_W + hcb_pkg::LEN_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_VISIT = 3'd2;
  localparam logic [2:0] S_KIDS  = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;

  logic [2:0]                 state;
  logic [CW-1:0]              cnt;
  logic [LW-1:0]              k;
  logic [NODE_CAP-1:0]        active;
  logic [IW-1:0]              scan_addr;
  logic                       p_v;
  logic [IW-1:0]              p_idx;
  logic                       phase;
  logic                       found;
  logic [IW-1:0]              best_idx;
  logic [WW-1:0]              best_w;
  logic [IW-1:0]              a_idx;
  logic [WW-1:0]              a_w;
  logic [IW-1:0]              cur_node;
  logic [hcb_pkg::CODE_W-1:0] cur_code;
  logic [hcb_pkg::LEN_W-1:0]  cur_len;
  logic [CW-1:0]              sp;

  logic [WW-1:0]             wmem [NODE_CAP];
  logic [2*IW-1:0]           kmem [MAX_SYMBOLS];
  logic [hcb_pkg::SYM_W-1:0] smem [MAX_SYMBOLS];
  logic [SW-1:0]             stk  [MAX_SYMBOLS];
  logic [WW-1:0]             wq;
  logic [2*IW-1:0]           kq;
  logic [hcb_pkg::SYM_W-1:0] sq;
  logic [SW-1:0]             stq;

  logic                      acc, store, scan_issue, scan_done, take, merge, more;
  logic                      leaf_node, emit;
  logic [CW-1:0]             n_next;
  logic [IW-1:0]             id;
  logic [LW-1:0]             kid_off;
  logic                      w_we;
  logic [IW-1:0]             w_wa;
  logic [WW-1:0]             w_wd;
  logic [IW-1:0]             zero_kid, one_kid;

  assign in_ready   = (state == S_LOAD) && !rst;
  assign acc        = in_valid && in_ready;
  assign store      = acc && (cnt < CW'(MAX_SYMBOLS));
  assign n_next     = store ? cnt + CW'(1) : cnt;
  assign scan_issue = (state == S_SCAN) && (scan_addr != IW'(NODE_CAP));
  assign scan_done  = (state == S_SCAN) && (scan_addr == IW'(NODE_CAP)) && !p_v;
  assign take       = p_v && active[p_idx] && (!found || wq < best_w);
  assign merge      = scan_done && phase;
  assign more       = ({1'b0, k} + (CW+1)'(2)) < {1'b0, cnt};
  assign id         = IW'(MAX_SYMBOLS) + IW'(k);
  assign kid_off    = LW'(cur_node - IW'(MAX_SYMBOLS));
  assign leaf_node  = cur_node < IW'(MAX_SYMBOLS);
  assign emit       = (state == S_LEAF) && (!out_valid || out_ready);
  assign zero_kid   = kq[2*IW-1:IW];
  assign one_kid    = kq[IW-1:0];

  always_comb begin
    w_we = 1'b0;
    w_wa = id;
    w_wd = a_w + best_w;
    if (store) begin
      w_we = 1'b1;
      w_wa = IW'(cnt);
      w_wd = WW'(frequency);
    end else if (merge) begin
      w_we = 1'b1;
    end
  end

  // node weight memory
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    if (scan_issue) begin
      wq <= wmem[scan_addr];
    end
  end

  // children of merged nodes, zero branch in the upper half
  always_ff @(posedge clk) begin
    if (merge) begin
      kmem[k] <= {a_idx, best_idx};
    end
    if (state == S_VISIT && !leaf_node) begin
      kq <= kmem[kid_off];
    end
  end

  // leaf symbol memory
  always_ff @(posedge clk) begin
    if (store) begin
      smem[cnt[LW-1:0]] <= symbol;
    end
    if (state == S_VISIT && leaf_node) begin
      sq <= smem[cur_node[LW-1:0]];
    end
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (state == S_KIDS) begin
      stk[sp[LW-1:0]] <= {one_kid, cur_code[hcb_pkg::CODE_W-2:0], 1'b1,
                          cur_len + hcb_pkg::LEN_W'(1)};
    end
    if (emit && sp != '0) begin
      stq <= stk[LW'(sp - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      k         <= '0;
      active    <= '0;
      scan_addr <= '0;
      p_v       <= 1'b0;
      phase     <= 1'b0;
      found     <= 1'b0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (store) begin
            active[IW'(cnt)] <= 1'b1;
          end
          if (acc) begin
            cnt <= n_next;
            if (last) begin
              k         <= '0;
              phase     <= 1'b0;
              found     <= 1'b0;
              scan_addr <= '0;
              p_v       <= 1'b0;
              cur_node  <= '0;
              cur_code  <= '0;
              cur_len   <= '0;
              sp        <= '0;
              state     <= (n_next == CW'(1)) ? S_VISIT : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          p_v   <= scan_issue;
          p_idx <= scan_addr;
          if (scan_issue) begin
            scan_addr <= scan_addr + IW'(1);
          end
          if (take) begin
            found    <= 1'b1;
            best_idx <= p_idx;
            best_w   <= wq;
          end
          if (scan_done) begin
            active[best_idx] <= 1'b0;
            found            <= 1'b0;
            scan_addr        <= '0;
            if (!phase) begin
              a_idx <= best_idx;
              a_w   <= best_w;
              phase <= 1'b1;
            end else begin
              active[id] <= 1'b1;
              phase      <= 1'b0;
              if (more) begin
                k <= k + LW'(1);
              end else begin
                cur_node <= id;
                state    <= S_VISIT;
              end
            end
          end
        end
        S_VISIT: begin
          state <= leaf_node ? S_LEAF : S_KIDS;
        end
        S_KIDS: begin
          sp       <= sp + CW'(1);
          cur_node <= zero_kid;
          cur_code <= {cur_code[hcb_pkg::CODE_W-2:0], 1'b0};
          cur_len  <= cur_len + hcb_pkg::LEN_W'(1);
          state    <= S_VISIT;
        end
        S_LEAF: begin
          if (emit) begin
            out_valid   <= 1'b1;
            symbol_res  <= sq;
            code_bits   <= cur_code;
            code_length <= cur_len;
            final_res   <= (sp == '0);
            if (sp == '0) begin
              active <= '0;
              cnt    <= '0;
              state  <= S_LOAD;
            end else begin
              sp    <= sp - CW'(1);
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          cur_node <= stq[SW-1:SW-IW];
          cur_code <= stq[hcb_pkg::CODE_W+hcb_pkg::LEN_W-1:hcb_pkg::LEN_W];
          cur_len  <= stq[hcb_pkg::LEN_W-1:0];
          state    <= S_VISIT;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule

// ----- rtl/hcb_checker.sv -----
// port-level checks for the huffman code builder, bound to the top level
`timescale 1ns / 1ps
`include "huffman_code_builder_macros.svh"
module hcb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hcb_pkg::SYM_W-1:0]  symbol_res,
  input logic [hcb_pkg::CODE_W-1:0] code_bits,
  input logic [hcb_pkg::LEN_W-1:0]  code_length
);
  `HCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_bits) && $stable(symbol_res))
  `HCB_ASSERT_NOW(a_code_clean, out_valid, (code_bits >> code_length) == '0)
  `HCB_ASSERT_NEXT(a_load_on, in_valid && in_ready && !last, in_ready)
  `HCB_ASSERT_NEXT(a_build_busy, in_valid && in_ready && last, !in_ready)
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);

// ----- sim/testbench.sv -----
// testbench for huffman_code_builder: directed table, random runs, scoreboard on codes
`timescale 1ns / 1ps
module testbench;
  localparam int SYM_W = hcb_pkg::SYM_W;
  localparam int FREQ_W = hcb_pkg::FREQ_W;
  localparam int CODE_W = hcb_pkg::CODE_W;
  localparam int LEN_W = hcb_pkg::LEN_W;

  localparam int NSYM = hcb_pkg::MAX_SYMBOLS_DEF;
  localparam int NNODE = 2 * NSYM - 1;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              fin;
  } code_t;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [FREQ_W-1:0] freq;
    logic              lst;
    bit                typed;
    code_t             want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [SYM_W-1:0] symbol = '0;
  logic [FREQ_W-1:0] frequency = '0;
  logic last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [SYM_W-1:0] symbol_res;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0] code_length;
  logic final_res;

  huffman_code_builder uut (.*);

  always #5 clk = ~clk;

  code_t codes_due[$];
  int mismatches = 0;
  int send_idle = 35;
  int recv_idle = 78;
  bit recv_hold = 0;
  int items_sent = 0;

  // tree model state
  logic [SYM_W-1:0] leaf_sym[NSYM];
  logic [21:0] node_wt[NNODE];
  logic [6:0] node_stamp[NNODE];
  bit node_live[NNODE];
  logic [6:0] zero_kid[NSYM-1];
  logic [6:0] one_kid[NSYM-1];
  int held = 0;

  function automatic int pick_lightest();
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int i = 0; i < NNODE; i++) begin
      if (node_live[i] && (!found || node_wt[i] < node_wt[best] ||
          (node_wt[i] == node_wt[best] && node_stamp[i] < node_stamp[best]))) begin
        best = i;
        found = 1;
      end
    end
    node_live[best] = 0;
    return best;
  endfunction

  task automatic absorb_item(input logic [SYM_W-1:0] s, input logic [FREQ_W-1:0] f,
                             input logic l, output code_t got[$]);
    int a, b, n, sp, nd, ln;
    int stk_node[NNODE];
    logic [CODE_W-1:0] stk_code[NNODE];
    int stk_len[NNODE];
    logic [CODE_W-1:0] cd;
    code_t c;
    got = {};
    if (held < NSYM) begin
      leaf_sym[held] = s;
      node_wt[held] = 22'(f);
      node_stamp[held] = 7'(held);
      node_live[held] = 1;
      held++;
    end
    if (!l) return;
    n = held;
    for (int k = 0; k + 1 < n; k++) begin
      a = pick_lightest();
      b = pick_lightest();
      zero_kid[k] = 7'(a);
      one_kid[k] = 7'(b);
      node_wt[NSYM + k] = node_wt[a] + node_wt[b];
      node_stamp[NSYM + k] = 7'(NSYM + k);
      node_live[NSYM + k] = 1;
    end
    stk_node[0] = (n > 1) ? NSYM + n - 2 : 0;
    stk_code[0] = '0;
    stk_len[0] = 0;
    sp = 1;
    while (sp > 0 && got.size() < NSYM) begin
      sp--;
      nd = stk_node[sp];
      cd = stk_code[sp];
      ln = stk_len[sp];
      if (nd < NSYM) begin
        c.sym = leaf_sym[nd];
        c.code = cd;
        c.len = LEN_W'(ln);
        c.fin = 0;
        got.push_back(c);
      end else if (sp + 2 <= NNODE && ln < 63) begin
        stk_node[sp] = int'(one_kid[nd - NSYM]);
        stk_code[sp] = {cd[CODE_W-2:0], 1'b1};
        stk_len[sp] = ln + 1;
        sp++;
        stk_node[sp] = int'(zero_kid[nd - NSYM]);
        stk_code[sp] = {cd[CODE_W-2:0], 1'b0};
        stk_len[sp] = ln + 1;
        sp++;
      end
    end
    if (got.size() > 0) got[got.size() - 1].fin = 1;
    for (int i = 0; i < NNODE; i++) node_live[i] = 0;
    held = 0;
  endtask

  // called right after the posedge; returns right after the accepting posedge
  task automatic send_item(input row_t r);
    code_t got[$];
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    symbol <= r.sym;
    frequency <= r.freq;
    last <= r.lst;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    absorb_item(r.sym, r.freq, r.lst, got);
    if (r.typed) codes_due.push_back(r.want);
    else foreach (got[i]) codes_due.push_back(got[i]);
    items_sent++;
    if (items_sent == 45) begin
      send_idle = 78;
      recv_idle = 35;
    end
    if (items_sent == 95) begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  task automatic send_run(input int n, input int fmode);
    row_t r;
    r.typed = 0;
    for (int i = 0; i < n; i++) begin
      r.sym = SYM_W'($urandom);
      case (fmode)
        0: r.freq = FREQ_W'($urandom);
        1: r.freq = FREQ_W'($urandom_range(3));
        default: r.freq = FREQ_W'($urandom_range(40));
      endcase
      r.lst = (i == n - 1);
      send_item(r);
    end
  endtask

  always @(posedge clk) begin
    if (recv_hold) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (codes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected code: sym %h", symbol_res);
      end else begin
        code_t w;
        w = codes_due.pop_front();
        if (w.sym !== symbol_res || w.code !== code_bits || w.len !== code_length ||
            w.fin !== final_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("code mismatch: exp sym %h code %h len %0d fin %b, got %h %h %0d %b",
                     w.sym, w.code, w.len, w.fin, symbol_res, code_bits, code_length,
                     final_res);
        end
      end
    end
  end

  // long output stall while items keep coming
  initial begin
    wait (items_sent == 50);
    recv_hold = 1;
    repeat (3000) @(posedge clk);
    recv_hold = 0;
  end

  initial begin
    #50_000_000;
    $display("huffman_code_builder verification failed");
    $finish;
  end

  row_t plan[$];
  function automatic row_t mk(input logic [7:0] s, input logic [15:0] f, input logic l,
                              input bit t = 0);
    row_t r;
    r.sym = s;
    r.freq = f;
    r.lst = l;
    r.typed = t;
    r.want.sym = s;
    r.want.code = '0;
    r.want.len = '0;
    r.want.fin = 1;
    return r;
  endfunction

  initial begin
    // single symbols, extremes
    plan.push_back(mk(8'hff, 16'hffff, 1, 1));
    plan.push_back(mk(8'h00, 16'h0000, 1, 1));
    // two symbols, lighter is the zero branch
    plan.push_back(mk(8'h41, 16'd5, 0));
    plan.push_back(mk(8'h42, 16'd3, 1));
    // equal weights break by load order
    plan.push_back(mk(8'h10, 16'd7, 0));
    plan.push_back(mk(8'h11, 16'd7, 0));
    plan.push_back(mk(8'h12, 16'd7, 0));
    plan.push_back(mk(8'h13, 16'd14, 1));
    // repeated symbols with zero frequencies, dollar sign included
    plan.push_back(mk(8'h24, 16'd0, 0));
    plan.push_back(mk(8'h24, 16'd0, 0));
    plan.push_back(mk(8'h24, 16'd0, 0));
    plan.push_back(mk(8'h55, 16'd1, 1));
    // full-scale weights
    plan.push_back(mk(8'haa, 16'hffff, 0));
    plan.push_back(mk(8'h55, 16'hffff, 0));
    plan.push_back(mk(8'h01, 16'h0001, 0));
    plan.push_back(mk(8'hfe, 16'h8000, 0));
    plan.push_back(mk(8'h80, 16'h7fff, 1));
    // skewed weights for a deep tree
    plan.push_back(mk(8'h61, 16'd1, 0));
    plan.push_back(mk(8'h62, 16'd1, 0));
    plan.push_back(mk(8'h63, 16'd2, 0));
    plan.push_back(mk(8'h64, 16'd4, 0));
    plan.push_back(mk(8'h65, 16'd8, 0));
    plan.push_back(mk(8'h66, 16'd16, 1));

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (plan[i]) send_item(plan[i]);
    while (items_sent < 60) begin
      case ($urandom_range(9))
        0: send_run(1, 0);
        1, 2, 3: send_run($urandom_range(2, 4), $urandom_range(2));
        default: send_run($urandom_range(3, 9), $urandom_range(2));
      endcase
    end
    // overflow: extra pairs beyond capacity are dropped, last one still builds
    send_run(NSYM + 6, 0);
    in_valid <= 0;
    last <= 0;
    while (codes_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && codes_due.size() == 0) begin
      $display("huffman_code_builder verification clean");
    end else begin
      $display("huffman_code_builder verification failed");
    end
    $finish;
  end
endmodule
